// ----- hw/rtl/tgi_pkg.sv -----
// tgi_pkg: sizes, widths and the blend function of the trilinear grid interpolator
// no dependencies; used by trilinear_grid_interpolator
`default_nettype none

package tgi_pkg;

  // grid and number format
  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS  = 8;

  // fixed field widths
  localparam int DIM_W      = 6;
  localparam int POS_W      = 13;
  localparam int VADDR_W    = 15;
  localparam int POS_INT_W  = POS_W - FRAC_BITS;

  // derived widths
  localparam int COORD_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ROW_W      = 2 * COORD_W;
  localparam int ADDR_W     = 3 * COORD_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int CMP_W      = ((POS_INT_W > DIM_W) ? POS_INT_W : DIM_W) + 1;
  localparam int MEM_W      = 2 * VALUE_BITS;
  localparam int LERP_W     = VALUE_BITS + FRAC_BITS + 2;

  // config register indexes
  localparam logic [1:0] REG_DIM_X = 2'd0;
  localparam logic [1:0] REG_DIM_Y = 2'd1;
  localparam logic [1:0] REG_DIM_Z = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

  // floor((a*(one-f) + b*f) / one)
  function automatic logic signed [VALUE_BITS-1:0] lerp(
    input logic signed [VALUE_BITS-1:0] a,
    input logic signed [VALUE_BITS-1:0] b,
    input logic [FRAC_BITS-1:0]         f
  );
    logic [FRAC_BITS:0]        g;
    logic signed [LERP_W-1:0]  wa;
    logic signed [LERP_W-1:0]  wb;
    logic signed [LERP_W-1:0]  s;
    logic signed [LERP_W-1:0]  sh;
    g  = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
    wa = LERP_W'(a) * $signed(LERP_W'(g));
    wb = LERP_W'(b) * $signed(LERP_W'(f));
    s  = wa + wb;
    sh = s >>> FRAC_BITS;
    return sh[VALUE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/trilinear_grid_interpolator.sv -----
// trilinear_grid_interpolator: periodic 3d complex voxel grid with trilinear queries
// depends on tgi_pkg
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ---------------------------
//  command   opcode_i voxel_address_i real/imag/pos   start_i high, busy_o low
//  config    cfg_index_i cfg_data_i                   cfg_we_i high
//  result    result_value_o range_error_o             result_valid_o, one cycle
//
// one transaction is accepted every cycle; busy_o stays low
// a query's result passes the seven register stages s1 to s6 and the output
// register; a write gives none
// the 8 corners are read in the same cycle from four copies of the grid memory,
// each copy read at two addresses; writes land in all copies at the read stage
// reset clears control state and sets each dimension to 32; grid contents
// are undefined until written, so no clearing pass is made
`default_nettype none

module trilinear_grid_interpolator (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  output logic                                        busy_o,
  input  wire logic                                   opcode_i,
  input  wire logic [tgi_pkg::VADDR_W-1:0]            voxel_address_i,
  input  wire logic signed [tgi_pkg::VALUE_BITS-1:0]  real_value_i,
  input  wire logic signed [tgi_pkg::VALUE_BITS-1:0]  imag_value_i,
  input  wire logic [tgi_pkg::POS_W-1:0]              pos_x_i,
  input  wire logic [tgi_pkg::POS_W-1:0]              pos_y_i,
  input  wire logic [tgi_pkg::POS_W-1:0]              pos_z_i,
  input  wire logic                                   want_imag_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [1:0]                             cfg_index_i,
  input  wire logic [tgi_pkg::DIM_W-1:0]              cfg_data_i,
  output logic                                        result_valid_o,
  output logic signed [tgi_pkg::VALUE_BITS-1:0]       result_value_o,
  output logic                                        range_error_o
);

  localparam int CW  = tgi_pkg::COORD_W;
  localparam int VB  = tgi_pkg::VALUE_BITS;
  localparam int FB  = tgi_pkg::FRAC_BITS;
  localparam int KW  = tgi_pkg::CMP_W;
  localparam int RW  = tgi_pkg::ROW_W;
  localparam int AW  = tgi_pkg::ADDR_W;
  localparam int MW  = tgi_pkg::MEM_W;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // dimension registers
  logic [tgi_pkg::DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= tgi_pkg::DIM_RESET;
      dim_y_q <= tgi_pkg::DIM_RESET;
      dim_z_q <= tgi_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgi_pkg::REG_DIM_X: dim_x_q <= cfg_data_i;
        tgi_pkg::REG_DIM_Y: dim_y_q <= cfg_data_i;
        tgi_pkg::REG_DIM_Z: dim_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective size: saturate to the grid, round down to even
  function automatic logic [KW-1:0] eff_dim(input logic [tgi_pkg::DIM_W-1:0] d);
    logic [KW-1:0] w;
    w = KW'(d);
    if (w > KW'(tgi_pkg::MAX_DIM)) w = KW'(tgi_pkg::MAX_DIM);
    w[0] = 1'b0;
    return w;
  endfunction

  // stage 0: corners, wrap and range check
  logic [KW-1:0] dx, dy, dz, ixw, iyw, izw, jxw, jyw, jzw;
  logic          err_d, wr_ok_d;

  always_comb begin
    dx  = eff_dim(dim_x_q);
    dy  = eff_dim(dim_y_q);
    dz  = eff_dim(dim_z_q);
    ixw = KW'(pos_x_i[tgi_pkg::POS_W-1:FB]);
    iyw = KW'(pos_y_i[tgi_pkg::POS_W-1:FB]);
    izw = KW'(pos_z_i[tgi_pkg::POS_W-1:FB]);
    jxw = (ixw + KW'(1) == dx) ? '0 : ixw + KW'(1);
    jyw = (iyw + KW'(1) == dy) ? '0 : iyw + KW'(1);
    jzw = (izw + KW'(1) == dz) ? '0 : izw + KW'(1);
    err_d   = (ixw >= dx) || (iyw >= dy) || (izw >= dz);
    wr_ok_d = 32'(voxel_address_i) < 32'(tgi_pkg::DEPTH);
  end

  // pipeline valid and kind bits
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, out_v_q;
  logic s1_qry_q, s2_qry_q, s3_qry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
      s5_v_q <= 1'b0; s6_v_q <= 1'b0; out_v_q <= 1'b0;
      s1_qry_q <= 1'b0; s2_qry_q <= 1'b0; s3_qry_q <= 1'b0;
    end else begin
      s1_v_q   <= accept;
      s1_qry_q <= opcode_i;
      s2_v_q   <= s1_v_q;
      s2_qry_q <= s1_qry_q;
      s3_v_q   <= s2_v_q;
      s3_qry_q <= s2_qry_q;
      s4_v_q   <= s3_v_q && s3_qry_q;
      s5_v_q   <= s4_v_q;
      s6_v_q   <= s5_v_q;
      out_v_q  <= s6_v_q;
    end
  end

  // payload registers
  logic          s1_err_q, s1_want_q, s1_wok_q;
  logic [AW-1:0] s1_waddr_q;
  logic [MW-1:0] s1_wdata_q;
  logic [FB-1:0] s1_fx_q, s1_fy_q, s1_fz_q;
  logic [CW-1:0] s1_ix_q, s1_jx_q, s1_iy_q, s1_jy_q, s1_iz_q, s1_jz_q;
  logic [KW-1:0] s1_dx_q, s1_dy_q;

  logic          s2_err_q, s2_want_q, s2_wok_q;
  logic [AW-1:0] s2_waddr_q;
  logic [MW-1:0] s2_wdata_q;
  logic [FB-1:0] s2_fx_q, s2_fy_q, s2_fz_q;
  logic [CW-1:0] s2_ix_q, s2_jx_q;
  logic [KW-1:0] s2_dx_q;
  logic [RW-1:0] s2_row_q [4];

  logic          s3_err_q, s3_want_q, s3_wok_q;
  logic [AW-1:0] s3_waddr_q;
  logic [MW-1:0] s3_wdata_q;
  logic [FB-1:0] s3_fx_q, s3_fy_q, s3_fz_q;
  logic [AW-1:0] s3_addr_q [8];

  logic          s4_err_q, s4_want_q;
  logic [FB-1:0] s4_fx_q, s4_fy_q, s4_fz_q;
  logic [MW-1:0] s4_rd_q [8];

  logic          s5_err_q;
  logic [FB-1:0] s5_fy_q, s5_fz_q;
  logic signed [VB-1:0] s5_val_q [4];

  logic          s6_err_q;
  logic [FB-1:0] s6_fz_q;
  logic signed [VB-1:0] s6_val_q [2];

  logic signed [VB-1:0] out_val_q;
  logic                 out_err_q;

  // corner selects from the stage-2 row base
  logic [CW-1:0] xsel [2];
  assign xsel[0] = s2_ix_q;
  assign xsel[1] = s2_jx_q;

  // stage-4 corner values for the chosen part
  logic signed [VB-1:0] corner [8];
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner[c] = s4_want_q ? s4_rd_q[c][MW-1:VB] : s4_rd_q[c][VB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: capture
    s1_err_q   <= err_d;
    s1_want_q  <= want_imag_i;
    s1_wok_q   <= wr_ok_d;
    s1_waddr_q <= AW'(voxel_address_i);
    s1_wdata_q <= {imag_value_i, real_value_i};
    s1_fx_q    <= pos_x_i[FB-1:0];
    s1_fy_q    <= pos_y_i[FB-1:0];
    s1_fz_q    <= pos_z_i[FB-1:0];
    s1_ix_q    <= ixw[CW-1:0];
    s1_jx_q    <= jxw[CW-1:0];
    s1_iy_q    <= iyw[CW-1:0];
    s1_jy_q    <= jyw[CW-1:0];
    s1_iz_q    <= izw[CW-1:0];
    s1_jz_q    <= jzw[CW-1:0];
    s1_dx_q    <= dx;
    s1_dy_q    <= dy;

    // stage 2: row index y + dy*z for the four y/z pairs
    s2_err_q   <= s1_err_q;
    s2_want_q  <= s1_want_q;
    s2_wok_q   <= s1_wok_q;
    s2_waddr_q <= s1_waddr_q;
    s2_wdata_q <= s1_wdata_q;
    s2_fx_q    <= s1_fx_q;
    s2_fy_q    <= s1_fy_q;
    s2_fz_q    <= s1_fz_q;
    s2_ix_q    <= s1_ix_q;
    s2_jx_q    <= s1_jx_q;
    s2_dx_q    <= s1_dx_q;
    s2_row_q[0] <= RW'(s1_iy_q) + RW'(RW'(s1_dy_q) * RW'(s1_iz_q));
    s2_row_q[1] <= RW'(s1_jy_q) + RW'(RW'(s1_dy_q) * RW'(s1_iz_q));
    s2_row_q[2] <= RW'(s1_iy_q) + RW'(RW'(s1_dy_q) * RW'(s1_jz_q));
    s2_row_q[3] <= RW'(s1_jy_q) + RW'(RW'(s1_dy_q) * RW'(s1_jz_q));

    // stage 3: linear corner addresses, corner = {z, y, x}
    s3_err_q   <= s2_err_q;
    s3_want_q  <= s2_want_q;
    s3_wok_q   <= s2_wok_q;
    s3_waddr_q <= s2_waddr_q;
    s3_wdata_q <= s2_wdata_q;
    s3_fx_q    <= s2_fx_q;
    s3_fy_q    <= s2_fy_q;
    s3_fz_q    <= s2_fz_q;
    for (int c = 0; c < 8; c++) begin
      s3_addr_q[c] <= AW'(xsel[c % 2]) + AW'(AW'(s2_dx_q) * AW'(s2_row_q[c / 2]));
    end

    // stage 4: memory read data arrives (see memory block)
    s4_err_q  <= s3_err_q;
    s4_want_q <= s3_want_q;
    s4_fx_q   <= s3_fx_q;
    s4_fy_q   <= s3_fy_q;
    s4_fz_q   <= s3_fz_q;

    // stage 5: blend along x
    s5_err_q <= s4_err_q;
    s5_fy_q  <= s4_fy_q;
    s5_fz_q  <= s4_fz_q;
    for (int k = 0; k < 4; k++) begin
      s5_val_q[k] <= tgi_pkg::lerp(corner[2*k], corner[2*k+1], s4_fx_q);
    end

    // stage 6: blend along y
    s6_err_q    <= s5_err_q;
    s6_fz_q     <= s5_fz_q;
    s6_val_q[0] <= tgi_pkg::lerp(s5_val_q[0], s5_val_q[1], s5_fy_q);
    s6_val_q[1] <= tgi_pkg::lerp(s5_val_q[2], s5_val_q[3], s5_fy_q);

    // output: blend along z, zero on range error
    out_err_q <= s6_err_q;
    out_val_q <= s6_err_q ? '0 : tgi_pkg::lerp(s6_val_q[0], s6_val_q[1], s6_fz_q);
  end

  // grid memory: four copies, each one write and two reads per cycle
  logic s3_we;
  assign s3_we = s3_v_q && !s3_qry_q && s3_wok_q;

  for (genvar m = 0; m < 4; m++) begin : g_copy
    logic [MW-1:0] grid_mem_q [tgi_pkg::DEPTH];

    always_ff @(posedge clk_i) begin
      if (s3_we) begin
        grid_mem_q[s3_waddr_q] <= s3_wdata_q;
      end
      s4_rd_q[2*m]   <= grid_mem_q[s3_addr_q[2*m]];
      s4_rd_q[2*m+1] <= grid_mem_q[s3_addr_q[2*m+1]];
    end
  end

  assign result_valid_o = out_v_q;
  assign result_value_o = out_val_q;
  assign range_error_o  = out_err_q;

  // range error always comes as a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |-> (result_value_o == '0))
    else $error("range error without zero result");

  // every accepted query gives a result after the pipeline latency
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i) |-> ##7 result_valid_o)
    else $error("query result missing");

  // writes give no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !opcode_i) |-> ##7 !result_valid_o)
    else $error("result from a write");

  // read data stage only carries queries
  a_read_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> $past(s3_v_q && s3_qry_q))
    else $error("read stage out of step");

endmodule

`default_nettype wire
